>>> rtl/pol_pkg.sv
// shared types and constants for the positional ordered list
// used by pol_ctrl, pol_datapath and positional_ordered_list_top
`default_nettype none

package pol_pkg;

    localparam int DEF_CAPACITY = 32;

    localparam int KIND_W    = 3;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 6;
    // wide enough for count+1 at the largest capacity
    localparam int CMP_W     = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // request codes
    localparam logic [KIND_W-1:0] REQ_INS_FIRST = 3'd0;
    localparam logic [KIND_W-1:0] REQ_INS_LAST  = 3'd1;
    localparam logic [KIND_W-1:0] REQ_INS_AT    = 3'd2;
    localparam logic [KIND_W-1:0] REQ_DEL_FIRST = 3'd3;
    localparam logic [KIND_W-1:0] REQ_DEL_LAST  = 3'd4;
    localparam logic [KIND_W-1:0] REQ_DEL_AT    = 3'd5;
    localparam logic [KIND_W-1:0] REQ_DUMP      = 3'd6;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL,
        OP_DUMP
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_COMMIT,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic shift;
        logic commit;
        logic dump_out;
    } cmd_t;

    typedef struct packed {
        op_t  dec_op;
        logic shift_done;
        logic out_free;
        logic dump_last;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/positional_ordered_list_top.sv
// insert/delete request: decided, then entries shifted (1..CAPACITY-1 moved), then committed
// one move per cycle through the single-port-write element memory, next request after commit
// dump: each element is a memory read, then the result register, the last one flagged
// a request that moves nothing, a rejected request or an empty list dump shifts no entries
// aresetn (synchronous, active low) empties the list and drops any pending result
// holds pol_pkg import, pol_ctrl and pol_datapath
`default_nettype none

module positional_ordered_list_top #(
    parameter int CAPACITY = pol_pkg::DEF_CAPACITY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pol_pkg::S_TDATA_W-1:0] s_tdata,  // position, value, zero pad
    input  wire logic [pol_pkg::KIND_W-1:0]    s_tuser,  // req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pol_pkg::M_TDATA_W-1:0]      m_tdata,  // element_count, element_value, zero pad
    output logic [pol_pkg::STAT_W-1:0]         m_tuser,  // status
    output logic                               m_tlast   // last_result
);
    import pol_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pol_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // one request in flight at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one is still in work");

    // only a dump result can be other than final, and a non-final dump result is ok
    a_error_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
        else $error("error or empty result not marked final");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[CNT_OUT_W-1:0] == CNT_OUT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[CNT_OUT_W-1:0] == '0))
        else $error("empty status with nonzero count");

endmodule

`default_nettype wire

>>> rtl/pol_ctrl.sv
// request sequencer for the positional ordered list
// depends on pol_pkg for state, command and status types
`default_nettype none

module pol_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  pol_pkg::stat_t      stat,
    output pol_pkg::cmd_t       cmd
);
    import pol_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = (stat.dec_op == OP_DUMP) ? S_DUMP_RD : S_SHIFT;
            end
            S_SHIFT: begin
                if (stat.shift_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECIDE: begin
                cmd.setup = 1'b1;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
            end
            S_COMMIT: begin
                cmd.commit = stat.out_free;
            end
            S_DUMP_OUT: begin
                cmd.dump_out = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/pol_datapath.sv
// element store, count, shift pointers and result register of the list
// depends on pol_pkg; driven by commands from pol_ctrl
`default_nettype none

module pol_datapath #(
    parameter int CAPACITY = pol_pkg::DEF_CAPACITY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  pol_pkg::cmd_t                      cmd,
    output pol_pkg::stat_t                     stat,
    input  wire logic [pol_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [pol_pkg::KIND_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pol_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [pol_pkg::STAT_W-1:0]         m_tuser,
    output logic                               m_tlast
);
    import pol_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // request fields
    logic [KIND_W-1:0]  kind_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VAL_W-1:0]   val_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    op_t                op_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   src_reg;
    logic [CNT_W-1:0]   moves_reg;
    logic               up_reg;
    logic               pend_reg;
    logic               pend_next;
    logic [CNT_W-1:0]   pend_src_reg;
    logic [VAL_W-1:0]   rd_data_reg;

    logic [VAL_W-1:0]   mem [CAPACITY];

    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [CNT_OUT_W-1:0] out_count_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic               out_last_reg;

    // decision on the captured request
    logic [CMP_W-1:0]   cnt8;
    logic [CMP_W-1:0]   pos8;
    op_t                dec_op;
    logic [STAT_W-1:0]  dec_status;
    logic [CMP_W-1:0]   dec_idx;
    logic [CMP_W-1:0]   dec_src;
    logic [CMP_W-1:0]   dec_moves;
    logic               dec_up;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VAL_W-1:0]   wr_data;
    logic [CNT_W-1:0]   wr_pos;
    logic               out_load;

    assign cnt8 = CMP_W'(count_reg);
    assign pos8 = CMP_W'(pos_reg);

    always_comb begin
        dec_op     = OP_NONE;
        dec_status = ST_OK;
        dec_idx    = '0;
        dec_src    = '0;
        dec_moves  = '0;
        dec_up     = 1'b0;
        case (kind_reg)
            REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AT: begin
                if (kind_reg == REQ_INS_FIRST) begin
                    dec_idx = '0;
                end else if (kind_reg == REQ_INS_LAST) begin
                    dec_idx = cnt8;
                end else begin
                    dec_idx = pos8 - CMP_W'(1);
                end
                // position is checked ahead of fullness
                if (kind_reg == REQ_INS_AT && (pos8 == '0 || pos8 > cnt8 + CMP_W'(1))) begin
                    dec_status = ST_BADPOS;
                end else if (cnt8 >= CMP_W'(CAPACITY)) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op    = OP_INS;
                    dec_moves = cnt8 - dec_idx;
                    dec_src   = cnt8 - CMP_W'(1);
                    dec_up    = 1'b0;
                end
            end
            REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AT: begin
                if (kind_reg == REQ_DEL_FIRST) begin
                    dec_idx = '0;
                end else if (kind_reg == REQ_DEL_LAST) begin
                    dec_idx = cnt8 - CMP_W'(1);
                end else begin
                    dec_idx = pos8 - CMP_W'(1);
                end
                if (cnt8 == '0) begin
                    dec_status = ST_EMPTY;
                end else if (kind_reg == REQ_DEL_AT && (pos8 == '0 || pos8 > cnt8)) begin
                    dec_status = ST_BADPOS;
                end else begin
                    dec_op    = OP_DEL;
                    dec_moves = cnt8 - CMP_W'(1) - dec_idx;
                    dec_src   = dec_idx + CMP_W'(1);
                    dec_up    = 1'b1;
                end
            end
            REQ_DUMP: begin
                if (cnt8 == '0) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op = OP_DUMP;
                end
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.commit && op_reg == OP_INS) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.commit && op_reg == OP_DEL) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign pend_next = cmd.shift && (moves_reg != '0);

    // moved entry lands one place above its source on insert, one below on delete
    assign wr_pos  = up_reg ? (pend_src_reg - CNT_W'(1)) : (pend_src_reg + CNT_W'(1));
    assign wr_en   = (cmd.shift && pend_reg) || (cmd.commit && op_reg == OP_INS);
    assign wr_addr = cmd.commit ? idx_reg[IDX_W-1:0] : wr_pos[IDX_W-1:0];
    assign wr_data = cmd.commit ? val_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[src_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_tuser;
            pos_reg  <= s_tdata[POS_W-1:0];
            val_reg  <= s_tdata[POS_W+VAL_W-1:POS_W];
        end
        if (cmd.setup) begin
            op_reg     <= dec_op;
            status_reg <= dec_status;
            idx_reg    <= dec_idx[CNT_W-1:0];
            src_reg    <= dec_src[CNT_W-1:0];
            moves_reg  <= dec_moves[CNT_W-1:0];
            up_reg     <= dec_up;
        end else if (cmd.shift && moves_reg != '0) begin
            src_reg   <= up_reg ? (src_reg + CNT_W'(1)) : (src_reg - CNT_W'(1));
            moves_reg <= moves_reg - CNT_W'(1);
        end else if (cmd.dump_out) begin
            src_reg <= src_reg + CNT_W'(1);
        end
        if (cmd.shift) begin
            pend_src_reg <= src_reg;
        end
        if (out_load) begin
            if (cmd.dump_out) begin
                out_status_reg <= ST_OK;
                out_count_reg  <= CNT_OUT_W'(count_reg);
                out_value_reg  <= rd_data_reg;
                out_last_reg   <= stat.dump_last;
            end else begin
                out_status_reg <= status_reg;
                out_count_reg  <= CNT_OUT_W'(count_next);
                out_value_reg  <= '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign out_load = cmd.commit || cmd.dump_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.dec_op     = dec_op;
        stat.shift_done = (moves_reg == '0) && !pend_reg;
        stat.out_free   = !out_valid_reg || m_tready;
        stat.dump_last  = (CMP_W'(src_reg) + CMP_W'(1)) == cnt8;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - CNT_OUT_W - VAL_W){1'b0}}, out_value_reg, out_count_reg};

endmodule

`default_nettype wire

>>> bench/list_checker.sv
// checker for positional_ordered_list_top: watches both stream channels,
// predicts the results of every request and compares them field by field
// depends on pol_pkg for the request and status codes
`default_nettype none

module list_checker #(
    parameter int CAPACITY = pol_pkg::DEF_CAPACITY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [pol_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [pol_pkg::KIND_W-1:0]    s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [pol_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [pol_pkg::STAT_W-1:0]    m_tuser,
    input  wire logic                          m_tlast,
    output int                                 mismatches,
    output int                                 pending_results,
    output int                                 list_len_q
);
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        logic [VAL_W-1:0]     value;
        logic                 last;
    } list_result_t;

    // shadow copy of the list, front at index 0
    logic [VAL_W-1:0] shadow_list[CAPACITY];
    int               list_len;
    list_result_t     awaited_results[$];
    list_result_t     oldest;

    initial begin
        mismatches      = 0;
        pending_results = 0;
        list_len_q      = 0;
        list_len        = 0;
    end

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic queue_result(input logic [STAT_W-1:0] st, input logic [VAL_W-1:0] val,
                                input logic last);
        list_result_t r;
        r.status = st;
        r.count  = list_len[CNT_OUT_W-1:0];
        r.value  = val;
        r.last   = last;
        awaited_results.push_back(r);
    endtask

    task automatic apply_list_request(input logic [KIND_W-1:0] kind,
                                      input logic [POS_W-1:0] pos,
                                      input logic [VAL_W-1:0] val);
        int                idx;
        int                k;
        logic [STAT_W-1:0] st;
        st = ST_OK;
        case (kind)
            REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AT: begin
                if (kind == REQ_INS_FIRST) idx = 0;
                else if (kind == REQ_INS_LAST) idx = list_len;
                else idx = int'(pos) - 1;
                // position is checked ahead of fullness
                if (kind == REQ_INS_AT && (pos < 1 || int'(pos) > list_len + 1)) begin
                    st = ST_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    for (k = list_len; k > idx; k--) shadow_list[k] = shadow_list[k-1];
                    shadow_list[idx] = val;
                    list_len++;
                end
            end
            REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AT: begin
                if (kind == REQ_DEL_FIRST) idx = 0;
                else if (kind == REQ_DEL_LAST) idx = list_len - 1;
                else idx = int'(pos) - 1;
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else if (kind == REQ_DEL_AT && (pos < 1 || int'(pos) > list_len)) begin
                    st = ST_BADPOS;
                end else begin
                    for (k = idx; k + 1 < list_len; k++) shadow_list[k] = shadow_list[k+1];
                    list_len--;
                end
            end
            REQ_DUMP: begin
                if (list_len == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < list_len; k++)
                        queue_result(ST_OK, shadow_list[k], k + 1 == list_len);
                end
                return;
            end
            default: ;
        endcase
        queue_result(st, '0, 1'b1);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            list_len = 0;
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_list_request(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W+VAL_W-1:POS_W]);
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no request waiting",
                                    m_tdata[CNT_OUT_W+VAL_W-1:CNT_OUT_W], '0);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_tuser !== oldest.status)
                        report_mismatch("status", VAL_W'(m_tuser), VAL_W'(oldest.status));
                    if (m_tdata[CNT_OUT_W-1:0] !== oldest.count)
                        report_mismatch("element_count", VAL_W'(m_tdata[CNT_OUT_W-1:0]),
                                        VAL_W'(oldest.count));
                    if (m_tdata[CNT_OUT_W+VAL_W-1:CNT_OUT_W] !== oldest.value)
                        report_mismatch("element_value", m_tdata[CNT_OUT_W+VAL_W-1:CNT_OUT_W],
                                        oldest.value);
                    if (m_tlast !== oldest.last)
                        report_mismatch("last_result", VAL_W'(m_tlast), VAL_W'(oldest.last));
                end
            end
        end
        // registered copies so the stimulus reads them without racing this block
        pending_results <= awaited_results.size();
        list_len_q      <= list_len;
    end

endmodule

`default_nettype wire

>>> bench/testbench.sv
// top of the bench: clock, reset, request stimulus, result back-pressure and verdict
// depends on pol_pkg, positional_ordered_list_top and list_checker
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int RANDOM_ITEMS   = 300;
    localparam int IDLE_LIMIT     = 1000;
    localparam int DRAIN_CYCLES   = 60;
    localparam logic [KIND_W-1:0] REQ_UNUSED = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 m_tlast;

    int mismatches;
    int pending_results;
    int list_len_q;

    int tx_gap;
    int tx_run_left = 0;
    bit tx_quiet = 1'b0;
    int rx_gap;
    int rx_wait = 0;
    int rx_run_left = 0;
    bit rx_quiet = 1'b0;
    int idle_cycles = 0;

    always #2 aclk = ~aclk;

    positional_ordered_list_top #(.CAPACITY(CAPACITY)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .list_len_q      (list_len_q)
    );

    function automatic logic [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // returns at the edge where the request is taken, tvalid still high
    task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val);
        if (tx_run_left == 0) begin
            tx_quiet    = ($urandom_range(0, 3) == 0);
            tx_run_left = $urandom_range(8, 40);
        end
        tx_run_left--;
        tx_gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (tx_gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (tx_gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-POS_W-VAL_W){1'b0}}, val, pos};
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side back-pressure, a fresh stall drawn after every result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (m_tready && m_tvalid) begin
            if (rx_run_left == 0) begin
                rx_quiet    = ($urandom_range(0, 3) == 0);
                rx_run_left = $urandom_range(8, 40);
            end
            rx_run_left--;
            rx_gap = rx_quiet ? 0 : $urandom_range(0, 16);
            if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_wait  <= rx_gap - 1;
            end
        end else if (!m_tready) begin
            if (rx_wait == 0) m_tready <= 1'b1;
            else rx_wait <= rx_wait - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        int                pick;
        int                n;
        bit                growing;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list corners, then corners on a short list
        issue_request(REQ_DEL_FIRST, 6'($urandom), draw_value());
        issue_request(REQ_DEL_LAST, 6'($urandom), draw_value());
        issue_request(REQ_DEL_AT, 6'd5, draw_value());
        issue_request(REQ_DUMP, 6'($urandom), draw_value());
        issue_request(REQ_INS_AT, 6'd0, draw_value());
        issue_request(REQ_INS_AT, 6'd2, draw_value());
        issue_request(REQ_INS_AT, 6'd1, 32'h8000_0000);
        issue_request(REQ_INS_FIRST, 6'd63, 32'h7fff_ffff);
        issue_request(REQ_INS_LAST, 6'd0, 32'hffff_ffff);
        issue_request(REQ_INS_AT, 6'd63, draw_value());
        issue_request(REQ_INS_AT, 6'd4, 32'h0000_0000);
        issue_request(REQ_DUMP, 6'd0, draw_value());
        issue_request(REQ_DEL_AT, 6'd0, draw_value());
        issue_request(REQ_DEL_AT, 6'd63, draw_value());
        issue_request(REQ_DEL_AT, 6'd2, draw_value());
        issue_request(REQ_DEL_FIRST, 6'($urandom), draw_value());
        issue_request(REQ_DEL_LAST, 6'($urandom), draw_value());
        issue_request(REQ_UNUSED, 6'($urandom), draw_value());
        // removing the only element empties the list
        issue_request(REQ_DEL_AT, 6'd1, draw_value());
        issue_request(REQ_DUMP, 6'($urandom), draw_value());

        // fill to capacity, then hit the full list
        for (n = 0; n < CAPACITY; n++) begin
            pick = $urandom_range(0, 2);
            kind = (pick == 0) ? REQ_INS_FIRST : (pick == 1) ? REQ_INS_LAST : REQ_INS_AT;
            issue_request(kind, (kind == REQ_INS_AT) ? 6'd1 : 6'($urandom), draw_value());
        end
        issue_request(REQ_INS_FIRST, 6'($urandom), draw_value());
        issue_request(REQ_INS_LAST, 6'($urandom), draw_value());
        issue_request(REQ_INS_AT, 6'(CAPACITY + 1), draw_value());
        issue_request(REQ_INS_AT, 6'(CAPACITY + 2), draw_value());
        issue_request(REQ_DUMP, 6'($urandom), draw_value());
        issue_request(REQ_DEL_AT, 6'(CAPACITY + 1), draw_value());
        issue_request(REQ_DEL_AT, 6'(CAPACITY), draw_value());
        issue_request(REQ_DEL_AT, 6'd1, draw_value());
        issue_request(REQ_INS_AT, 6'(CAPACITY - 1), draw_value());

        // random phases of growth and shrinkage, positions mostly legal
        growing = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (list_len_q == 0) growing = 1'b1;
            else if (list_len_q >= CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
            else if ($urandom_range(0, 29) == 0) growing = !growing;

            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                kind = REQ_DUMP;
            end else if (pick < 7) begin
                kind = REQ_UNUSED;
            end else if (pick < (growing ? 75 : 30)) begin
                pick = $urandom_range(0, 2);
                kind = (pick == 0) ? REQ_INS_FIRST : (pick == 1) ? REQ_INS_LAST : REQ_INS_AT;
            end else begin
                pick = $urandom_range(0, 2);
                kind = (pick == 0) ? REQ_DEL_FIRST : (pick == 1) ? REQ_DEL_LAST : REQ_DEL_AT;
            end

            if (kind == REQ_INS_AT && $urandom_range(0, 4) != 0)
                pos = 6'($urandom_range(1, list_len_q + 1));
            else if (kind == REQ_DEL_AT && $urandom_range(0, 4) != 0)
                pos = 6'($urandom_range(1, (list_len_q > 0) ? list_len_q : 1));
            else
                pos = 6'($urandom_range(0, 63));

            issue_request(kind, pos, draw_value());
        end
        s_tvalid <= 1'b0;

        // let the checker see the last request before looking at what is left
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
